// File: hdl/rv32is_pkg.sv
package rv32is_pkg;

  // Major opcodes of the base integer instruction set.
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_ALUI   = 7'h13;
  localparam logic [6:0] OPC_ALUR   = 7'h33;

  // funct7 code that selects subtract and arithmetic shift right.
  localparam logic [6:0] F7_ALT = 7'h20;

  // ALU function codes carried in funct3.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Branch condition codes carried in funct3.
  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;
  localparam logic [2:0] BR_GEU = 3'd7;

  localparam int unsigned XLEN    = 32;
  localparam int unsigned NUM_REG = 32;
  localparam int unsigned REG_AW  = 5;

  // One committed instruction as reported on the result channel.
  typedef struct packed {
    logic [XLEN-1:0] instr_pc;
    logic [XLEN-1:0] commit_value;
    logic [XLEN-1:0] commit_target;
    logic [XLEN-1:0] following_pc;
  } commit_t;

  // Register file write request from the execute stage.
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } rf_write_t;

endpackage

// File: hdl/rv32is_in_if.sv
interface rv32is_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

// File: hdl/rv32is_out_if.sv
interface rv32is_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_pc;
  logic [31:0] commit_value;
  logic [31:0] commit_target;
  logic [31:0] following_pc;

  modport source (
    output valid, output instr_pc, output commit_value,
    output commit_target, output following_pc, input ready
  );
  modport sink (
    input valid, input instr_pc, input commit_value,
    input commit_target, input following_pc, output ready
  );
endinterface

// File: hdl/rv32is_ram.sv
module rv32is_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Synchronous write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rv32is_exec.sv
module rv32is_exec
  import rv32is_pkg::*;
(
  input  logic [31:0]     instr_i,
  input  logic [XLEN-1:0] pc_i,
  input  logic [XLEN-1:0] rs1_i,
  input  logic [XLEN-1:0] rs2_i,
  output commit_t         commit_o,
  output rf_write_t       wr_o
);

  logic [6:0]        opc;
  logic [REG_AW-1:0] rd;
  logic [2:0]        f3;
  logic [REG_AW-1:0] r2;
  logic [6:0]        f7;
  logic [XLEN-1:0]   imm_i, imm_s, imm_b, imm_j, imm_u;
  logic [XLEN-1:0]   seq_pc;
  logic [XLEN-1:0]   alu_b;
  logic              alu_alt;
  logic [XLEN-1:0]   alu_res;
  logic [4:0]        shamt;
  logic              taken;
  logic [XLEN-1:0]   value, target, next_pc;
  logic              wr_en;

  // Instruction fields and immediates.
  assign opc   = instr_i[6:0];
  assign rd    = instr_i[11:7];
  assign f3    = instr_i[14:12];
  assign r2    = instr_i[24:20];
  assign f7    = instr_i[31:25];
  assign imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                  instr_i[11:8], 1'b0};
  assign imm_j = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                  instr_i[30:21], 1'b0};
  assign imm_u = {instr_i[31:12], 12'h000};
  assign seq_pc = pc_i + 32'd4;

  // ALU operand and alternate-function selection.
  always_comb begin
    alu_b   = rs2_i;
    alu_alt = 1'b0;
    if (opc == OPC_ALUI) begin
      alu_b   = (f3[1:0] == 2'b01) ? {27'd0, r2} : imm_i;
      alu_alt = (f3 == F3_SR) && (f7 == F7_ALT);
    end else if (opc == OPC_ALUR) begin
      alu_alt = (f7 == F7_ALT);
    end
  end

  assign shamt = alu_b[4:0];

  // ALU.
  always_comb begin
    unique case (f3)
      F3_ADD:  alu_res = alu_alt ? rs1_i - alu_b : rs1_i + alu_b;
      F3_SLL:  alu_res = rs1_i << shamt;
      F3_SLT:  alu_res = {31'd0, $signed(rs1_i) < $signed(alu_b)};
      F3_SLTU: alu_res = {31'd0, rs1_i < alu_b};
      F3_XOR:  alu_res = rs1_i ^ alu_b;
      F3_SR:   alu_res = alu_alt ? 32'($signed(rs1_i) >>> shamt) : rs1_i >> shamt;
      F3_OR:   alu_res = rs1_i | alu_b;
      F3_AND:  alu_res = rs1_i & alu_b;
      default: alu_res = rs1_i & alu_b;
    endcase
  end

  // Branch compare; the two reserved condition codes are never taken.
  always_comb begin
    unique case (f3)
      BR_EQ:   taken = (rs1_i == rs2_i);
      BR_NE:   taken = (rs1_i != rs2_i);
      BR_LT:   taken = $signed(rs1_i) < $signed(rs2_i);
      BR_GE:   taken = $signed(rs1_i) >= $signed(rs2_i);
      BR_LTU:  taken = rs1_i < rs2_i;
      BR_GEU:  taken = rs1_i >= rs2_i;
      default: taken = 1'b0;
    endcase
  end

  // Commit decode per opcode; unknown opcodes write the ALU result on rs1 and rs2 with no alternate function.
  always_comb begin
    value   = '0;
    target  = {27'd0, rd};
    next_pc = seq_pc;
    wr_en   = 1'b1;
    unique case (opc)
      OPC_LUI:   value = imm_u;
      OPC_AUIPC: value = pc_i + imm_u;
      OPC_JAL: begin
        value   = seq_pc;
        next_pc = pc_i + imm_j;
      end
      OPC_JALR: begin
        value   = seq_pc;
        next_pc = (rs1_i + imm_i) & ~32'd1;
      end
      OPC_BRANCH: begin
        target = '0;
        wr_en  = 1'b0;
        if (taken) begin
          next_pc = pc_i + imm_b;
        end
      end
      OPC_LOAD:  value = '0;
      OPC_STORE: begin
        value  = rs2_i;
        target = rs1_i + imm_s;
        wr_en  = 1'b0;
      end
      default:   value = alu_res;
    endcase
  end

  assign commit_o.instr_pc      = pc_i;
  assign commit_o.commit_value  = value;
  assign commit_o.commit_target = target;
  assign commit_o.following_pc  = next_pc;

  assign wr_o.en   = wr_en && (rd != '0);
  assign wr_o.addr = rd;
  assign wr_o.data = value;

endmodule

// File: hdl/rv32i_instruction_step_unit.sv
// An accepted instruction passes through the execute stage registers and then the
// output register before its result transaction is offered.
// Throughput: one instruction per cycle while the output drains, set by the register
// file RAM read feeding the execute stage, with a bypass for back-to-back writes.
// Reset clears the pc, the pipeline valids and the register file valid bits,
// so every register reads as zero until written; no clearing pass is needed.
module rv32i_instruction_step_unit
  import rv32is_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  rv32is_in_if.sink    in_i,
  rv32is_out_if.source out_o
);

  logic              in_fire;
  logic              ex_fire;
  logic              ex_valid_q;
  logic [31:0]       ex_instr_q;
  logic [XLEN-1:0]   pc_q;
  logic [NUM_REG-1:0] rf_valid_q;
  logic              rs1_ok_q, rs2_ok_q;
  logic              byp_en_q;
  logic [REG_AW-1:0] byp_addr_q;
  logic [XLEN-1:0]   byp_data_q;
  logic [XLEN-1:0]   ram_a, ram_b;
  logic [XLEN-1:0]   rs1_val, rs2_val;
  commit_t           commit;
  rf_write_t         wr;
  logic              out_valid_q;
  commit_t           out_q;
  logic [REG_AW-1:0] rs1_addr, rs2_addr;
  logic [REG_AW-1:0] ex_rs1, ex_rs2;

  assign rs1_addr = in_i.instruction[19:15];
  assign rs2_addr = in_i.instruction[24:20];
  assign ex_rs1   = ex_instr_q[19:15];
  assign ex_rs2   = ex_instr_q[24:20];

  // Handshake: execute retires when the output register is free or drains.
  assign ex_fire    = ex_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !ex_valid_q || ex_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  // Register file: two copies, one read port each, written together.
  rv32is_ram #(
    .Width (XLEN),
    .Depth (NUM_REG)
  ) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (wr.en && ex_fire),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (in_fire),
    .raddr_i (rs1_addr),
    .rdata_o (ram_a)
  );

  rv32is_ram #(
    .Width (XLEN),
    .Depth (NUM_REG)
  ) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (wr.en && ex_fire),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (in_fire),
    .raddr_i (rs2_addr),
    .rdata_o (ram_b)
  );

  // Execute stage control and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
      pc_q       <= '0;
      rf_valid_q <= '0;
      byp_en_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        ex_valid_q <= 1'b1;
        // Capture the write that lands in the same cycle as the read.
        byp_en_q   <= wr.en && ex_fire;
      end else if (ex_fire) begin
        ex_valid_q <= 1'b0;
      end
      if (ex_fire) begin
        pc_q <= commit.following_pc;
        if (wr.en) begin
          rf_valid_q[wr.addr] <= 1'b1;
        end
      end
    end
  end

  // Execute stage payload, taken with the RAM read.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ex_instr_q <= in_i.instruction;
      rs1_ok_q   <= rf_valid_q[rs1_addr];
      rs2_ok_q   <= rf_valid_q[rs2_addr];
      byp_addr_q <= wr.addr;
      byp_data_q <= wr.data;
    end
  end

  // Operand selection: bypass, then written RAM entry, else reset zero.
  always_comb begin
    if (byp_en_q && (byp_addr_q == ex_rs1)) begin
      rs1_val = byp_data_q;
    end else if (rs1_ok_q) begin
      rs1_val = ram_a;
    end else begin
      rs1_val = '0;
    end
    if (byp_en_q && (byp_addr_q == ex_rs2)) begin
      rs2_val = byp_data_q;
    end else if (rs2_ok_q) begin
      rs2_val = ram_b;
    end else begin
      rs2_val = '0;
    end
  end

  rv32is_exec u_exec (
    .instr_i  (ex_instr_q),
    .pc_i     (pc_q),
    .rs1_i    (rs1_val),
    .rs2_i    (rs2_val),
    .commit_o (commit),
    .wr_o     (wr)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ex_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      out_q <= commit;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.instr_pc      = out_q.instr_pc;
  assign out_o.commit_value  = out_q.commit_value;
  assign out_o.commit_target = out_q.commit_target;
  assign out_o.following_pc  = out_q.following_pc;

endmodule
